// ===== rtl/aoc_pkg.sv =====
// shared widths, latency and divider operand type for the alpha-over compositor
`default_nettype none

package aoc_pkg;

    localparam int CHAN_W    = 8;
    localparam int QUOT_W    = CHAN_W;
    localparam int DEN_W     = 2 * CHAN_W;
    localparam int NUM_W     = 25;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STG   = QUOT_W / DIV_STEPS;
    // three arithmetic stages, the divider stages, one output register
    localparam int AOC_LAT   = 3 + DIV_STG + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zero;
    } t_div_in;

endpackage

`default_nettype wire

// ===== rtl/aoc_div.sv =====
// pipelined restoring divider for one color channel, saturating 8-bit quotient
`default_nettype none

module aoc_div
    import aoc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_div_in           i_op,
    output logic [QUOT_W-1:0]      o_quot
);

    logic [NUM_W-1:0]  w_rem  [DIV_STG];
    logic [DEN_W-1:0]  w_den  [DIV_STG];
    logic [QUOT_W-1:0] w_quot [DIV_STG];
    logic              w_zero [DIV_STG];
    logic              w_sat  [DIV_STG];

    logic [NUM_W-1:0]  r_rem  [DIV_STG];
    logic [DEN_W-1:0]  r_den  [DIV_STG];
    logic [QUOT_W-1:0] r_quot [DIV_STG];
    logic              r_zero [DIV_STG];
    logic              r_sat  [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        logic [NUM_W-1:0]  n_rem;
        logic [QUOT_W-1:0] n_quot;

        if (s == 0) begin : g_first
            assign w_rem[s]  = i_op.num;
            assign w_den[s]  = i_op.den;
            assign w_quot[s] = '0;
            assign w_zero[s] = i_op.zero;
            // quotient would not fit in 8 bits
            assign w_sat[s]  = i_op.num >= NUM_W'({i_op.den, {QUOT_W{1'b0}}});
        end else begin : g_next
            assign w_rem[s]  = r_rem[s-1];
            assign w_den[s]  = r_den[s-1];
            assign w_quot[s] = r_quot[s-1];
            assign w_zero[s] = r_zero[s-1];
            assign w_sat[s]  = r_sat[s-1];
        end

        always_comb begin
            logic [NUM_W-1:0]  rem;
            logic [NUM_W-1:0]  trial;
            logic [QUOT_W-1:0] quot;
            int                b;
            rem  = w_rem[s];
            quot = w_quot[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                b     = QUOT_W - 1 - s * DIV_STEPS - j;
                trial = NUM_W'(w_den[s]) << b;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    quot = quot | (QUOT_W'(1) << b);
                end
            end
            n_rem  = rem;
            n_quot = quot;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_den[s]  <= w_den[s];
            r_quot[s] <= n_quot;
            r_zero[s] <= w_zero[s];
            r_sat[s]  <= w_sat[s];
        end
    end

    always_comb begin
        priority if (r_zero[DIV_STG-1]) begin
            o_quot = '0;
        end else if (r_sat[DIV_STG-1]) begin
            o_quot = CHAN_MAX;
        end else begin
            o_quot = r_quot[DIV_STG-1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/alpha_over_compositor.sv =====
// alpha-over compositor top level: argb8888 foreground over background
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-------------------------------
//  command   | i_foreground_pixel, i_background_pixel | start while busy low = transfer
//  result    | o_blended_pixel                        | o_strobe, one cycle, no stall
//
//  one pixel pair per cycle; busy is raised only while reset is held
//  from transfer to strobe a pixel passes AOC_LAT stages: three arithmetic stages,
//  four divider stages of two quotient bits each, one output register
//  the receiver cannot hold results off, so nothing in the pipeline ever waits
//  reset clears only the valid bits; data registers are free running
`default_nettype none

module alpha_over_compositor
    import aoc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_foreground_pixel,
    input  wire logic [31:0] i_background_pixel,
    output logic             o_strobe,
    output logic [31:0]      o_blended_pixel
);

    localparam int NCH = 3;

    // floor(x / 255) for x below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [DEN_W-1:0] x);
        logic [DEN_W:0] t;
        t = {1'b0, x} + (DEN_W+1)'(x >> CHAN_W) + (DEN_W+1)'(1);
        return t[DEN_W-1:CHAN_W];
    endfunction

    logic              xfer;
    logic [CHAN_W-1:0] fa;
    logic [CHAN_W-1:0] ba;
    logic [AOC_LAT-1:0] r_vld;

    // no command is taken while reset is held
    assign busy = !i_rst_n;
    assign xfer = start && !busy;
    assign fa   = i_foreground_pixel[31:24];
    assign ba   = i_background_pixel[31:24];

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[AOC_LAT-2:0], xfer};
        end
    end

    // stage 1: 8x8 products and the inverse foreground alpha
    logic [DEN_W-1:0]  r1_p;
    logic [CHAN_W-1:0] r1_ifa;
    logic [DEN_W-1:0]  r1_ff [NCH];
    logic [DEN_W-1:0]  r1_bb [NCH];

    always_ff @(posedge i_clk) begin
        r1_p   <= (CHAN_MAX - ba) * (CHAN_MAX - fa);
        r1_ifa <= CHAN_MAX - fa;
        for (int c = 0; c < NCH; c++) begin
            r1_ff[c] <= i_foreground_pixel[c*CHAN_W +: CHAN_W] * fa;
            r1_bb[c] <= i_background_pixel[c*CHAN_W +: CHAN_W] * ba;
        end
    end

    // stage 2: result alpha and channel numerators
    logic [CHAN_W-1:0] r2_a;
    logic [NUM_W-1:0]  r2_num [NCH];

    always_ff @(posedge i_clk) begin
        r2_a <= CHAN_MAX - div255(r1_p);
        for (int c = 0; c < NCH; c++) begin
            // 255 * ff as shift and subtract, plus bb * (255 - fa)
            r2_num[c] <= (NUM_W'(r1_ff[c]) << CHAN_W) - NUM_W'(r1_ff[c])
                       + NUM_W'(r1_bb[c]) * NUM_W'(r1_ifa);
        end
    end

    // stage 3: divisor a * 255 and the zero-alpha flag
    t_div_in           r3_op [NCH];
    logic [CHAN_W-1:0] r_adly [DIV_STG+1];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            r3_op[c].num  <= r2_num[c];
            r3_op[c].den  <= (DEN_W'(r2_a) << CHAN_W) - DEN_W'(r2_a);
            r3_op[c].zero <= (r2_a == '0);
        end
        r_adly[0] <= r2_a;
        for (int k = 1; k <= DIV_STG; k++) begin
            r_adly[k] <= r_adly[k-1];
        end
    end

    // stages 4 to 7: one divider lane per color channel
    logic [QUOT_W-1:0] w_q [NCH];

    for (genvar c = 0; c < NCH; c++) begin : g_lane
        aoc_div u_div (
            .i_clk  (i_clk),
            .i_op   (r3_op[c]),
            .o_quot (w_q[c])
        );
    end

    // stage 8: output register, channels back in their own byte positions
    logic [31:0] r_out;

    always_ff @(posedge i_clk) begin
        r_out <= {r_adly[DIV_STG], w_q[2], w_q[1], w_q[0]};
    end

    assign o_strobe        = r_vld[AOC_LAT-1];
    assign o_blended_pixel = r_out;

endmodule

`default_nettype wire

// ===== rtl/aoc_checker.sv =====
// port-level checks for the alpha-over compositor, bound to the top level
`default_nettype none

module aoc_checker
    import aoc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] i_foreground_pixel,
    input wire logic [31:0] i_background_pixel,
    input wire logic        o_strobe,
    input wire logic [31:0] o_blended_pixel
);

    // every transfer is followed by its strobe
    a_strobe_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##AOC_LAT o_strobe)
        else $error("transfer without result");

    a_xfer_before_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, AOC_LAT))
        else $error("result without transfer");

    // zero result alpha clears the color channels
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_blended_pixel[31:24] == 8'h00) |-> o_blended_pixel[23:0] == 24'h0)
        else $error("color left over at zero alpha");

    // opaque foreground passes through unchanged
    a_opaque_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_foreground_pixel[31:24], AOC_LAT) == CHAN_MAX)
        |-> o_blended_pixel == $past(i_foreground_pixel, AOC_LAT))
        else $error("opaque foreground altered");

    // clear foreground over opaque background gives the background
    a_clear_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_foreground_pixel[31:24], AOC_LAT) == 8'h00
         && $past(i_background_pixel[31:24], AOC_LAT) == CHAN_MAX)
        |-> o_blended_pixel == $past(i_background_pixel, AOC_LAT))
        else $error("background altered under clear foreground");

endmodule

bind alpha_over_compositor aoc_checker u_aoc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_foreground_pixel (i_foreground_pixel),
    .i_background_pixel (i_background_pixel),
    .o_strobe           (o_strobe),
    .o_blended_pixel    (o_blended_pixel)
);

`default_nettype wire
